/* rtl/mspt_pkg.sv */
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared types and constants for the multi-slot periodic timer table.
// ----------------------------------------------------------------------------
package mspt_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_ADDED       = 2'd0,
        KIND_FIRED       = 2'd1,
        KIND_NOTHING_DUE = 2'd2,
        KIND_TABLE_FULL  = 2'd3
    } kind_t;

    // One slot memory word
    typedef struct packed {
        logic [63:0] due;
        logic [31:0] period;
        logic [31:0] handle;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture the input transfer
        logic add;         // arm a free slot or report table full
        logic scan_clr;    // restart the slot scan
        logic mark_issue;  // read next slot, mark it pending if due
        logic sel_issue;   // read next slot, track earliest pending
        logic fire;        // report and retire the earliest pending slot
        logic none_due;    // report nothing due
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;   // current scan address is the last slot
        logic pend_none;   // no slot left to fire
        logic pend_one;    // exactly one slot left to fire
        logic out_free;    // result register can take a result
    } dp_stat_t;

endpackage

/* rtl/mspt_dp.sv */
// ----------------------------------------------------------------------------
// mspt_dp
// Slot memory, valid and pending bits, scan pipeline and result register.
// ----------------------------------------------------------------------------
module mspt_dp #(
    parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mspt_pkg::dp_cmd_t               cmd,
    output mspt_pkg::dp_stat_t              stat,
    input  logic [mspt_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mspt_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // Slot memory
    mspt_pkg::entry_t mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]     pend_cnt_reg, pend_cnt_next;

    logic [63:0] now_reg;
    logic [31:0] delay_reg;
    logic [31:0] period_reg;
    logic [31:0] handle_reg, handle_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             cmp_mark_reg;
    mspt_pkg::entry_t rd_data_reg;

    logic             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    mspt_pkg::entry_t best_reg, best_next;

    logic                 out_vld_reg, out_vld_next;
    mspt_pkg::kind_t      out_kind_reg, out_kind_next;
    logic [31:0]          out_handle_reg, out_handle_next;
    logic                 out_last_reg, out_last_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    mspt_pkg::entry_t     wr_data;

    logic [NUM_SLOTS-1:0] free_vec;
    logic [NUM_SLOTS-1:0] free_low;
    logic [IDX_W-1:0]     free_idx;
    logic                 full;
    logic                 rd_en;

    // Lowest free slot
    always_comb begin
        free_vec = ~valid_reg;
        free_low = free_vec & (~free_vec + NUM_SLOTS'(1));
        full     = (free_vec == '0);
        free_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (free_low[i]) begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    assign rd_en = cmd.mark_issue | cmd.sel_issue;

    always_comb begin
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        pend_cnt_next   = pend_cnt_reg;
        handle_next     = handle_reg;
        scan_idx_next   = scan_idx_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        out_vld_next    = out_vld_reg & ~m_tready;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = free_idx;
        wr_data         = '{due: now_reg + {32'd0, delay_reg}, period: period_reg,
                            handle: handle_reg + 32'd1};

        if (cmd.load) begin
            pend_cnt_next = '0;
        end

        if (cmd.scan_clr) begin
            scan_idx_next = '0;
            best_vld_next = 1'b0;
        end else if (rd_en) begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        // Compare stage on the registered read data
        if (cmp_vld_reg) begin
            if (cmp_mark_reg) begin
                pend_next[cmp_idx_reg] = valid_reg[cmp_idx_reg] &&
                                         (rd_data_reg.due <= now_reg);
                if (valid_reg[cmp_idx_reg] && (rd_data_reg.due <= now_reg)) begin
                    pend_cnt_next = pend_cnt_reg + CNT_W'(1);
                end
            end else if (pend_reg[cmp_idx_reg] &&
                         (!best_vld_reg || (rd_data_reg.due < best_reg.due))) begin
                best_vld_next = 1'b1;
                best_idx_next = cmp_idx_reg;
                best_next     = rd_data_reg;
            end
        end

        if (cmd.add) begin
            out_vld_next = 1'b1;
            out_last_next = 1'b1;
            if (full) begin
                out_kind_next   = mspt_pkg::KIND_TABLE_FULL;
                out_handle_next = '0;
            end else begin
                wr_en                 = 1'b1;
                valid_next[free_idx]  = 1'b1;
                handle_next           = handle_reg + 32'd1;
                out_kind_next         = mspt_pkg::KIND_ADDED;
                out_handle_next       = handle_reg + 32'd1;
            end
        end

        if (cmd.fire) begin
            out_vld_next            = 1'b1;
            out_kind_next           = mspt_pkg::KIND_FIRED;
            out_handle_next         = best_reg.handle;
            out_last_next           = (pend_cnt_reg == CNT_W'(1));
            pend_next[best_idx_reg] = 1'b0;
            pend_cnt_next           = pend_cnt_reg - CNT_W'(1);
            wr_addr                 = best_idx_reg;
            wr_data                 = '{due: best_reg.due + {32'd0, best_reg.period},
                                        period: best_reg.period,
                                        handle: best_reg.handle};
            if (best_reg.period != 32'd0) begin
                wr_en = 1'b1;
            end else begin
                valid_next[best_idx_reg] = 1'b0;
            end
        end

        if (cmd.none_due) begin
            out_vld_next    = 1'b1;
            out_kind_next   = mspt_pkg::KIND_NOTHING_DUE;
            out_handle_next = '0;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
            handle_reg   <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_mark_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            pend_reg     <= pend_next;
            pend_cnt_reg <= pend_cnt_next;
            handle_reg   <= handle_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= rd_en;
            cmp_mark_reg <= cmd.mark_issue;
            best_vld_reg <= best_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg    <= s_tdata[63:0];
            delay_reg  <= s_tdata[95:64];
            period_reg <= s_tdata[127:96];
        end
        cmp_idx_reg    <= scan_idx_reg;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.scan_last = (scan_idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign stat.pend_none = (pend_cnt_reg == '0);
    assign stat.pend_one  = (pend_cnt_reg == CNT_W'(1));
    assign stat.out_free  = ~out_vld_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_handle_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/mspt_ctrl.sv */
// ----------------------------------------------------------------------------
// mspt_ctrl
// Sequencer for add and check operations of the timer table.
// ----------------------------------------------------------------------------
module mspt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  action,
    input  mspt_pkg::dp_stat_t    stat,
    output mspt_pkg::dp_cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_ADD      = 9'b000000010,
        ST_MARK     = 9'b000000100,
        ST_MARK_END = 9'b000001000,
        ST_DECIDE   = 9'b000010000,
        ST_NONE     = 9'b000100000,
        ST_SEL      = 9'b001000000,
        ST_SEL_END  = 9'b010000000,
        ST_FIRE     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = action ? ST_MARK : ST_ADD;
                end
            end
            ST_ADD: begin
                if (stat.out_free) begin
                    cmd.add    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MARK: begin
                cmd.mark_issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_MARK_END;
                end
            end
            ST_MARK_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.scan_clr = 1'b1;
                state_next   = stat.pend_none ? ST_NONE : ST_SEL;
            end
            ST_NONE: begin
                if (stat.out_free) begin
                    cmd.none_due = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SEL: begin
                cmd.sel_issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_SEL_END;
                end
            end
            ST_SEL_END: begin
                state_next = ST_FIRE;
            end
            ST_FIRE: begin
                if (stat.out_free) begin
                    cmd.fire     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = stat.pend_one ? ST_IDLE : ST_SEL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/multi_slot_periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_table
// Table of one-shot and periodic timer slots with due-order firing.
// ----------------------------------------------------------------------------
// The block holds NUM_SLOTS timer slots in a single-port slot memory, one
// slot read per cycle. An add transfer (s_tuser = 0) arms the lowest free
// slot at now + delay and returns the new handle, or table_full, once
// the result register is free. A check transfer (s_tuser = 1) first
// scans all slots to mark the due ones, then for each due slot runs a
// selection scan over the memory and emits one fired result; a check
// that finds nothing due returns nothing_due. Fired slots come out
// earliest due first, ties to the lower slot; a periodic slot is
// re-armed at due + period and a one-shot slot is freed. A new input
// transfer is taken once the previous item's last result sits in the
// output register.
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer_table #(
    parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] now_us, [95:64] delay_us, [127:96] period_us
    input  logic [mspt_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] action: 0 add, 1 check and fire
    input  logic                            s_tuser,
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] timer_handle
    output logic [mspt_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [1:0]                      m_tuser,
    // last result of the input item
    output logic                            m_tlast
);

    mspt_pkg::dp_cmd_t  cmd;
    mspt_pkg::dp_stat_t stat;

    // Sequence add, mark scan, selection scans and result transfers
    mspt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the slots, compare due times, drive the result register
    mspt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
